// File: sv/hps_pkg.sv
package hps_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int LANES       = 3;
	localparam int MAX_WIDTH   = 4096;
	localparam int COL_BITS    = 12;
	localparam int ROW_BITS    = 16;
	localparam int WREG_BITS   = 13;
	localparam int APB_AW      = 4;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR    = 2;

	// register byte addresses
	localparam logic [APB_AW-1:0] REG_IMAGE_WIDTH  = 4'h0;
	localparam logic [APB_AW-1:0] REG_IMAGE_HEIGHT = 4'h4;
	localparam logic [APB_AW-1:0] REG_COLOR_MODE   = 4'h8;

	localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 13'd4096;
	localparam logic [ROW_BITS-1:0]  HEIGHT_RESET = 16'd1;
	localparam logic                 MODE_RESET   = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [LANES-1:0] pix_t;
	typedef logic [COL_BITS-1:0] col_t;
	typedef logic [ROW_BITS-1:0] row_t;

	typedef struct packed {
		pix_t px;
		col_t col;
		row_t row;
		logic last;
	} res_t;

	// what stage 1 hands to the merge stage in one cycle
	typedef struct packed {
		logic fix_valid;
		logic raw_valid;
		pix_t fixed;
		pix_t raw;
		col_t col;
		row_t row;
		logic last;
	} mrg_push_t;

	typedef struct packed {
		logic [WREG_BITS-1:0] width;
		row_t                 height;
		logic                 color;
	} cfg_t;

endpackage

// File: sv/hps_if.sv
interface hps_in_if;
	logic                  valid;
	logic                  ready;
	logic [15:0]           sample_0;
	logic [15:0]           sample_1;
	logic [15:0]           sample_2;

	modport source (output valid, output sample_0, output sample_1, output sample_2,
		input ready);
	modport sink (input valid, input sample_0, input sample_1, input sample_2,
		output ready);
endinterface

interface hps_out_if;
	logic                  valid;
	logic                  ready;
	logic [15:0]           out_0;
	logic [15:0]           out_1;
	logic [15:0]           out_2;
	logic [11:0]           out_column;
	logic [15:0]           out_row;
	logic                  frame_last;

	modport source (output valid, output out_0, output out_1, output out_2,
		output out_column, output out_row, output frame_last, input ready);
	modport sink (input valid, input out_0, input out_1, input out_2,
		input out_column, input out_row, input frame_last, output ready);
endinterface

// File: sv/hps_ram.sv
module hps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/hps_cfg.sv
module hps_cfg import hps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [WREG_BITS-1:0] width_q;
	row_t                 height_q;
	logic                 color_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			color_q  <= MODE_RESET;
		end else if (wr_en) begin
			unique case (paddr)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[WREG_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[ROW_BITS-1:0];
				REG_COLOR_MODE:   color_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			REG_IMAGE_WIDTH:  prdata = {{(32-WREG_BITS){1'b0}}, width_q};
			REG_IMAGE_HEIGHT: prdata = {{(32-ROW_BITS){1'b0}}, height_q};
			REG_COLOR_MODE:   prdata = {31'd0, color_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign cfg = '{width: width_q, height: height_q, color: color_q};

endmodule

// File: sv/hps_lane.sv
module hps_lane import hps_pkg::*; (
	input  sample_t center,
	input  sample_t left,
	input  sample_t right,
	input  sample_t up,
	input  sample_t down,
	input  logic    interior,
	output sample_t fixed
);

	logic [SAMPLE_BITS+1:0] c_x;
	logic                   hot;

	assign c_x = {2'b00, center};

	// strictly above four times every neighbor
	assign hot = (c_x > {left, 2'b00}) && (c_x > {right, 2'b00})
		&& (c_x > {up, 2'b00}) && (c_x > {down, 2'b00});

	assign fixed = (interior && hot) ? '0 : center;

endmodule

// File: sv/hps_merge.sv
module hps_merge import hps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      color,
	input  mrg_push_t push,
	output logic      space,
	hps_out_if.source res
);

	res_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR-1:0] wr_q;
	logic [FIFO_PTR-1:0] rd_q;
	logic [FIFO_PTR:0]   cnt_q;
	logic                pop;
	logic [FIFO_PTR-1:0] wr_b;
	logic [FIFO_PTR-1:0] n_push;
	res_t                fix_r;
	res_t                raw_r;
	pix_t                fix_m;
	pix_t                raw_m;
	res_t                head;

	// gray mode shows channels 1 and 2 as zero
	always_comb begin
		fix_m = push.fixed;
		raw_m = push.raw;
		if (!color) begin
			fix_m[1] = '0;
			fix_m[2] = '0;
			raw_m[1] = '0;
			raw_m[2] = '0;
		end
	end

	assign fix_r = '{px: fix_m, col: push.col, row: push.row - row_t'(1), last: 1'b0};
	assign raw_r = '{px: raw_m, col: push.col, row: push.row, last: push.last};

	assign n_push = FIFO_PTR'(push.fix_valid) + FIFO_PTR'(push.raw_valid);
	assign wr_b   = push.fix_valid ? wr_q + FIFO_PTR'(1) : wr_q;
	assign pop    = res.valid && res.ready;
	assign space  = cnt_q <= (FIFO_PTR+1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.fix_valid) begin
			fifo_q[wr_q] <= fix_r;
		end
		if (push.raw_valid) begin
			fifo_q[wr_b] <= raw_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + FIFO_PTR'(pop);
			cnt_q <= cnt_q + (FIFO_PTR+1)'(n_push) - (FIFO_PTR+1)'(pop);
		end
	end

	assign head           = fifo_q[rd_q];
	assign res.valid      = cnt_q != '0;
	assign res.out_0      = head.px[0];
	assign res.out_1      = head.px[1];
	assign res.out_2      = head.px[2];
	assign res.out_column = head.col;
	assign res.out_row    = head.row;
	assign res.frame_last = head.last;

endmodule

// File: sv/hot_pixel_suppressor_top.sv
// Hot pixel suppressor.
// pix_in takes one pixel per beat in raster order (sample_0..2); pix_out gives
// result beats tagged with column and row. A pixel off the frame border is
// zeroed per channel when it is strictly above 4x each of its four neighbors
// (left/up already corrected, right/down raw). A row is emitted corrected
// when the row below arrives; last-row pixels also go out raw, right after
// the corrected pixel above them, and frame_last marks the raw last pixel.
// Gray mode (color_mode = 0) zeroes channels 1 and 2.
// APB registers: 0x0 image_width, 0x4 image_height, 0x8 color_mode; write
// them only while the block is idle.
// Throughput: one pixel per cycle while pix_out is ready and each pixel yields
// at most one result; on the last row each pixel yields two, so the output
// port sets the pace at one result per cycle. A result beat is offered once
// the pixel that causes it has passed stage 1 and entered the result queue.
// Reset clears position counters, registers and the output queue; the line
// stores are not cleared and need none (every entry is written by a row
// before it is read). When pix_out stalls, stage 1 keeps pushing while the
// four-entry result queue holds two or fewer; with three or four queued the
// pixel in stage 1 waits and pix_in.ready drops until room opens.
module hot_pixel_suppressor_top import hps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	hps_in_if.sink            pix_in,
	hps_out_if.source         pix_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;

	hps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---- position and frame geometry (accept stage) ----
	col_t                 col_q;
	row_t                 row_q;
	logic [WREG_BITS-1:0] w_eff;
	row_t                 h_eff;
	col_t                 x;
	row_t                 r;
	logic [WREG_BITS-1:0] x_p1;
	logic [ROW_BITS:0]    r_p1;
	logic                 accept;
	pix_t                 px_in;

	// out-of-range register values clamp to the legal frame
	assign w_eff = (cfg.width == '0) ? WREG_BITS'(1)
		: (cfg.width > WREG_BITS'(MAX_WIDTH)) ? WREG_BITS'(MAX_WIDTH) : cfg.width;
	assign h_eff = (cfg.height == '0) ? ROW_BITS'(1) : cfg.height;

	// a shrunk frame restarts the position
	assign x    = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
	assign r    = (row_q >= h_eff) ? '0 : row_q;
	assign x_p1 = {1'b0, x} + WREG_BITS'(1);
	assign r_p1 = {1'b0, r} + (ROW_BITS+1)'(1);

	always_comb begin
		px_in[0] = pix_in.sample_0;
		px_in[1] = cfg.color ? pix_in.sample_1 : '0;
		px_in[2] = cfg.color ? pix_in.sample_2 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (x_p1 >= w_eff) begin
				col_q <= '0;
				row_q <= (r_p1 >= {1'b0, h_eff}) ? '0 : r_p1[ROW_BITS-1:0];
			end else begin
				col_q <= x_p1[COL_BITS-1:0];
			end
		end
	end

	// ---- stage 1 registers ----
	logic  v_s1;
	logic  adv_s1;
	logic  space;
	pix_t  px_s1;
	col_t  x_s1;
	row_t  r_s1;
	logic  interior_s1;
	logic  upper_s1;
	logic  raw_s1;
	logic  last_s1;
	logic  fwd_s1;
	pix_t  fwd_px_s1;

	assign adv_s1       = v_s1 && space;
	assign pix_in.ready = !v_s1 || adv_s1;
	assign accept       = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= px_in;
			x_s1        <= x;
			r_s1        <= r;
			interior_s1 <= (x != '0) && ({1'b0, x} + WREG_BITS'(2) <= w_eff)
				&& (r >= ROW_BITS'(2));
			upper_s1    <= r != '0;
			raw_s1      <= r_p1 == {1'b0, h_eff};
			last_s1     <= x_p1 == w_eff;
			// narrow frames: the pixel leaving stage 1 now writes the entry read now
			fwd_s1      <= v_s1 && (x_s1 == x);
			fwd_px_s1   <= px_s1;
		end
	end

	// ---- line stores ----
	// raw row above is kept twice so x and x+1 read in one cycle
	pix_t prev_a_rd;
	pix_t prev_b_rd;
	pix_t corr_rd;
	pix_t fixed_s1;

	hps_ram #(.WIDTH(SAMPLE_BITS*LANES), .DEPTH(MAX_WIDTH)) u_prev_a (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (x_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (x),
		.rdata (prev_a_rd)
	);

	hps_ram #(.WIDTH(SAMPLE_BITS*LANES), .DEPTH(MAX_WIDTH)) u_prev_b (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (x_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (x + col_t'(1)),
		.rdata (prev_b_rd)
	);

	hps_ram #(.WIDTH(SAMPLE_BITS*LANES), .DEPTH(MAX_WIDTH)) u_corr (
		.clk   (clk),
		.we    (adv_s1 && upper_s1),
		.waddr (x_s1),
		.wdata (fixed_s1),
		.re    (accept),
		.raddr (x),
		.rdata (corr_rd)
	);

	// ---- per-channel lanes ----
	pix_t center;
	pix_t left_q;

	assign center = fwd_s1 ? fwd_px_s1 : prev_a_rd;

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		hps_lane u_lane (
			.center   (center[c]),
			.left     (left_q[c]),
			.right    (prev_b_rd[c]),
			.up       (corr_rd[c]),
			.down     (px_s1[c]),
			.interior (interior_s1),
			.fixed    (fixed_s1[c])
		);
	end

	// last corrected pixel, the left neighbor of the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (adv_s1 && upper_s1) begin
			left_q <= fixed_s1;
		end
	end

	// ---- merge and output queue ----
	mrg_push_t push;

	assign push = '{
		fix_valid: adv_s1 && upper_s1,
		raw_valid: adv_s1 && raw_s1,
		fixed:     fixed_s1,
		raw:       px_s1,
		col:       x_s1,
		row:       r_s1,
		last:      last_s1
	};

	hps_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.color  (cfg.color),
		.push   (push),
		.space  (space),
		.res    (pix_out)
	);

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hps_pkg::*;

	localparam int RAND_ITEMS    = 800;
	localparam int WIDE_ITEMS    = 40;    // pixels sent into the clamped over-range width
	localparam int SETTLE_CYCLES = 8;     // settling margin for idle checks
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 200;   // long sink hold-off, fills the result queue
	localparam int STALL_LIMIT   = 2000;  // cycles without any beat or register access before giving up
	localparam int SHOWN_ERRORS  = 10;

	typedef enum {STEP_WRITE, STEP_PIXEL} step_kind_t;
	typedef enum {TEX_NOISE, TEX_DARK_SPOTS, TEX_THRESHOLD, TEX_EXTREMES} texture_t;

	// one row of the directed table: a register write or a pixel beat,
	// optionally with its single result typed in
	typedef struct {
		step_kind_t        kind;
		logic [APB_AW-1:0] addr;
		logic [31:0]       data;
		pix_t              px;
		bit                typed;
		res_t              want;
	} dir_step_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	hps_in_if  pix_in();
	hps_out_if pix_out();

	hot_pixel_suppressor_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: registers, both line stores, left neighbor, position
	// ------------------------------------------------------------------
	logic [WREG_BITS-1:0] cfg_width  = WIDTH_RESET;
	row_t                 cfg_height = HEIGHT_RESET;
	logic                 cfg_color  = MODE_RESET;

	pix_t        raw_line  [MAX_WIDTH];   // raw row above the current one
	pix_t        fixed_line[MAX_WIDTH];   // corrected row two above
	pix_t        left_fixed = '0;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	res_t      due_pixels[$];             // results still owed by the block
	dir_step_t plan[$];

	int err_cnt     = 0;
	int sent_cnt    = 0;
	int checked_cnt = 0;
	int hot_cnt     = 0;
	int frame_cnt   = 0;

	bit tx_calm  = 1'b0;
	bit rx_calm  = 1'b0;
	bit hold_req = 1'b0;

	function automatic void log_error(string msg);
		err_cnt++;
		if (err_cnt <= SHOWN_ERRORS)
			$display("%0t ns  ERROR  %s", $realtime, msg);
	endfunction

	function automatic res_t want_pixel(sample_t s0, sample_t s1, sample_t s2,
		int unsigned col, int unsigned row, bit last);
		res_t r;
		r.px   = {s2, s1, s0};
		r.col  = col_t'(col);
		r.row  = row_t'(row);
		r.last = last;
		return r;
	endfunction

	// gray mode blanks channels 1 and 2 on the way out
	function automatic res_t pack_result(pix_t p, int unsigned col, int unsigned row, bit last);
		if (!cfg_color) begin
			p[1] = '0;
			p[2] = '0;
		end
		return want_pixel(p[0], p[1], p[2], col, row, last);
	endfunction

	// One accepted pixel: emits the corrected pixel above it (rows >= 1) and,
	// on the last row, the raw pixel itself. Results go to due_pixels if keep.
	function automatic void suppress_step(pix_t raw_in, bit keep);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned r;
		pix_t        px;
		pix_t        fixed;
		logic [17:0] mid;
		logic [17:0] lf;
		logic [17:0] rt;
		logic [17:0] up;
		logic [17:0] dn;
		bit          interior;

		w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
		h = (cfg_height == 0) ? 1 : cfg_height;
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		r = row_pos;

		px = raw_in;
		if (!cfg_color) begin
			px[1] = '0;
			px[2] = '0;
		end

		if (r >= 1) begin
			interior = (x >= 1) && (x + 2 <= w) && (r >= 2);
			fixed = raw_line[x];
			if (interior) begin
				for (int c = 0; c < LANES; c++) begin
					mid = {2'b00, raw_line[x][c]};
					lf  = {2'b00, left_fixed[c]} << 2;
					rt  = {2'b00, raw_line[x + 1][c]} << 2;
					up  = {2'b00, fixed_line[x][c]} << 2;
					dn  = {2'b00, px[c]} << 2;
					if (mid > lf && mid > rt && mid > up && mid > dn) begin
						fixed[c] = '0;
						hot_cnt++;
					end
				end
			end
			if (keep) due_pixels.push_back(pack_result(fixed, x, r - 1, 1'b0));
			fixed_line[x] = fixed;
			left_fixed    = fixed;
		end

		raw_line[x] = px;

		if (r + 1 == h && keep)
			due_pixels.push_back(pack_result(px, x, r, x + 1 == w));

		if (x + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else
			col_pos = x + 1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus content
	// ------------------------------------------------------------------
	function automatic sample_t make_sample(texture_t tex, sample_t base);
		int roll;
		roll = $urandom_range(0, 9);
		case (tex)
			TEX_NOISE:      return sample_t'($urandom_range(0, 65535));
			TEX_DARK_SPOTS: return sample_t'((roll < 2) ? $urandom_range(1024, 65535)
				: $urandom_range(0, 255));
			// hot by one code, exactly on the limit, or background
			TEX_THRESHOLD:  return sample_t'((roll < 2) ? base * 4 + 1
				: ((roll < 3) ? base * 4 : base));
			default: begin
				if (roll == 0) return '0;
				else if (roll == 1) return '1;
				else if (roll < 4) return sample_t'($urandom_range(0, 65535));
				else return sample_t'($urandom_range(0, 15));
			end
		endcase
	endfunction

	function automatic pix_t make_pixel(texture_t tex, sample_t base);
		pix_t p;
		for (int c = 0; c < LANES; c++)
			p[c] = make_sample(tex, base);
		return p;
	endfunction

	// idle cycles between beats: mostly none, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		else if (roll < 90) return $urandom_range(1, 3);
		else if (roll < 97) return $urandom_range(4, 10);
		else return $urandom_range(20, 60);
	endfunction

	function automatic int pick_stall();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(1, 3);
		else if (roll < 95) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	function automatic void add_write(logic [APB_AW-1:0] addr, logic [31:0] data);
		dir_step_t st;
		st = '{kind: STEP_WRITE, addr: addr, data: data, px: '0, typed: 1'b0, want: '0};
		plan.push_back(st);
	endfunction

	function automatic void add_pixel(sample_t s0, sample_t s1, sample_t s2);
		dir_step_t st;
		st = '{kind: STEP_PIXEL, addr: '0, data: '0, px: {s2, s1, s0}, typed: 1'b0, want: '0};
		plan.push_back(st);
	endfunction

	function automatic void add_pixel_want(sample_t s0, sample_t s1, sample_t s2, res_t want);
		dir_step_t st;
		st = '{kind: STEP_PIXEL, addr: '0, data: '0, px: {s2, s1, s0}, typed: 1'b1, want: want};
		plan.push_back(st);
	endfunction

	// ------------------------------------------------------------------
	// Bus tasks
	// ------------------------------------------------------------------
	task automatic send_pixel(pix_t p, bit typed, res_t want);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk) pix_in.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_in.valid    <= 1'b1;
		pix_in.sample_0 <= p[0];
		pix_in.sample_1 <= p[1];
		pix_in.sample_2 <= p[2];
		do @(posedge clk); while (!pix_in.ready);
		if (typed) begin
			suppress_step(p, 1'b0);
			due_pixels.push_back(want);
		end else
			suppress_step(p, 1'b1);
		sent_cnt++;
	endtask

	// drop valid and wait until the block has nothing left in flight
	task automatic wait_idle();
		@(negedge clk) pix_in.valid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			REG_IMAGE_WIDTH:  cfg_width  = data[WREG_BITS-1:0];
			REG_IMAGE_HEIGHT: cfg_height = data[ROW_BITS-1:0];
			REG_COLOR_MODE:   cfg_color  = data[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, bit color);
		wait_idle();
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
		reg_write(REG_COLOR_MODE, {31'd0, color});
	endtask

	// ------------------------------------------------------------------
	// Result checker: every result beat against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		res_t  got;
		res_t  want;
		string bad;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			got.px   = {pix_out.out_2, pix_out.out_1, pix_out.out_0};
			got.col  = pix_out.out_column;
			got.row  = pix_out.out_row;
			got.last = pix_out.frame_last;
			if (due_pixels.size() == 0)
				log_error($sformatf("unexpected result %h/%h/%h col %0d row %0d last %b",
					got.px[0], got.px[1], got.px[2], got.col, got.row, got.last));
			else begin
				want = due_pixels.pop_front();
				bad  = "";
				if (got.px[0] !== want.px[0]) bad = {bad, " out_0"};
				if (got.px[1] !== want.px[1]) bad = {bad, " out_1"};
				if (got.px[2] !== want.px[2]) bad = {bad, " out_2"};
				if (got.col !== want.col) bad = {bad, " out_column"};
				if (got.row !== want.row) bad = {bad, " out_row"};
				if (got.last !== want.last) bad = {bad, " frame_last"};
				if (bad != "")
					log_error($sformatf(
						"bad%s: exp %h/%h/%h c%0d r%0d l%b, got %h/%h/%h c%0d r%0d l%b",
						bad, want.px[0], want.px[1], want.px[2], want.col, want.row, want.last,
						got.px[0], got.px[1], got.px[2], got.col, got.row, got.last));
				checked_cnt++;
			end
		end
	end

	// watchdog: no beat on either stream and no register access for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
			(psel && penable))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d results outstanding",
					STALL_LIMIT, due_pixels.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result sink: random stalls, calm stretches, and one long hold-off on request
	initial begin : result_sink
		pix_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pix_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				pix_out.ready <= 1'b1;
			end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
				pix_out.ready <= 1'b0;
				repeat (pick_stall()) @(negedge clk);
				pix_out.ready <= 1'b1;
			end else
				pix_out.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		bit          dirty;
		int          n;
		int          pause_at;
		int          roll;
		int unsigned w_pick;
		int unsigned h_pick;
		int          rand_items;
		texture_t    tex;
		sample_t     base;

		arst_n          = 1'b0;
		pix_in.valid    = 1'b0;
		pix_in.sample_0 = '0;
		pix_in.sample_1 = '0;
		pix_in.sample_2 = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;

		// reset values: 4096 wide, one row, color -> every pixel comes back raw
		add_pixel_want(16'h0000, 16'h0000, 16'h0000,
			want_pixel(16'h0000, 16'h0000, 16'h0000, 0, 0, 1'b0));
		add_pixel_want(16'hFFFF, 16'hFFFF, 16'hFFFF,
			want_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 1'b0));
		// shrink width under the current column: restarts at column 0
		add_write(REG_IMAGE_WIDTH, 2);
		add_pixel_want(16'h1234, 16'h5678, 16'h9ABC,
			want_pixel(16'h1234, 16'h5678, 16'h9ABC, 0, 0, 1'b0));
		add_pixel_want(16'hA5A5, 16'h5A5A, 16'h0001,
			want_pixel(16'hA5A5, 16'h5A5A, 16'h0001, 1, 0, 1'b1));
		// gray, width 0 and height 0 both act as 1
		add_write(REG_COLOR_MODE, 0);
		add_write(REG_IMAGE_WIDTH, 0);
		add_write(REG_IMAGE_HEIGHT, 0);
		add_pixel_want(16'hFFFF, 16'h8001, 16'h7FFE,
			want_pixel(16'hFFFF, 16'h0000, 16'h0000, 0, 0, 1'b1));
		add_pixel_want(16'h8000, 16'hFFFF, 16'hFFFF,
			want_pixel(16'h8000, 16'h0000, 16'h0000, 0, 0, 1'b1));
		// 3x3 color frame: center hot in ch0 (401 > 400), on the limit in ch1, hot in ch2
		add_write(REG_IMAGE_WIDTH, 3);
		add_write(REG_IMAGE_HEIGHT, 3);
		add_write(REG_COLOR_MODE, 1);
		repeat (4) add_pixel(16'd100, 16'd100, 16'd100);
		add_pixel(16'd401, 16'd400, 16'hFFFF);
		repeat (4) add_pixel(16'd100, 16'd100, 16'd100);
		// tallest frame, two rows in, then height cut below the current row
		add_write(REG_IMAGE_HEIGHT, 65535);
		add_pixel(16'h0000, 16'hFFFF, 16'h0000);
		add_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		add_pixel(16'h0007, 16'h0008, 16'h0009);
		add_pixel(16'h0001, 16'h0002, 16'h0003);
		add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pixel(16'h0000, 16'h0000, 16'h0000);
		add_write(REG_IMAGE_HEIGHT, 2);
		add_pixel(16'h0010, 16'h2000, 16'hF000);
		add_pixel(16'h0200, 16'h0030, 16'h0004);
		add_pixel(16'h4000, 16'h0100, 16'h0800);
		// gray between rows: stored color row goes out with channels 1 and 2 blanked
		add_write(REG_COLOR_MODE, 0);
		add_pixel(16'h0011, 16'h2222, 16'h3333);
		add_pixel(16'h0005, 16'h4444, 16'h5555);
		add_pixel(16'hFFFE, 16'h6666, 16'h7777);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		dirty = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				if (dirty) wait_idle();
				dirty = 1'b0;
				reg_write(plan[i].addr, plan[i].data);
			end else begin
				send_pixel(plan[i].px, plan[i].typed, plan[i].want);
				dirty = 1'b1;
			end
		end
		frame_cnt += 5;

		// width 8191 acts as 4096: part of one row, every pixel raw, frame_last low;
		// the next width write lands under the column and restarts it
		set_frame(8191, 1, 1'b1);
		for (int i = 0; i < WIDE_ITEMS; i++)
			send_pixel(make_pixel(TEX_NOISE, '0), 1'b0, '0);
		frame_cnt++;

		// back-pressure: sink holds off while pixels keep coming, then the
		// source waits mid-frame for every result to drain
		set_frame(16, 4, 1'b1);
		tx_calm  = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 64; i++) begin
			if (i == 40) begin
				@(negedge clk) pix_in.valid <= 1'b0;
				while (due_pixels.size() != 0) @(posedge clk);
			end
			send_pixel(make_pixel(TEX_DARK_SPOTS, '0), 1'b0, '0);
		end
		tx_calm = 1'b0;
		frame_cnt++;

		// random whole frames, mostly small
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll == 0) w_pick = 0;
			else if (roll <= 2) w_pick = roll;
			else if (roll <= 14) w_pick = $urandom_range(3, 12);
			else if (roll <= 18) w_pick = $urandom_range(13, 48);
			else w_pick = $urandom_range(100, 200);
			roll = $urandom_range(0, 9);
			if (roll == 0) h_pick = 0;
			else if (roll == 1) h_pick = 1;
			else if (roll == 9) h_pick = $urandom_range(10, 14);
			else h_pick = $urandom_range(2, 7);
			if (w_pick > 48) h_pick = $urandom_range(1, 3);
			n = ((w_pick == 0) ? 1 : w_pick) * ((h_pick == 0) ? 1 : h_pick);

			set_frame(w_pick, h_pick, 1'($urandom_range(0, 1)));
			tex      = texture_t'($urandom_range(0, 3));
			base     = sample_t'($urandom_range(1, 16383));
			tx_calm  = ($urandom_range(0, 3) == 0);
			rx_calm  = ($urandom_range(0, 3) == 0);
			pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
			for (int i = 0; i < n; i++) begin
				if (i == pause_at) begin
					@(negedge clk) pix_in.valid <= 1'b0;
					while (due_pixels.size() != 0) @(posedge clk);
				end
				send_pixel(make_pixel(tex, base), 1'b0, '0);
			end
			rand_items += n;
			frame_cnt++;
		end

		@(negedge clk) pix_in.valid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixels over %0d frames (widths 1..200 and a clamped 8191,",
			sent_cnt, frame_cnt);
		$display("heights up to 65535, gray+color); %0d result beats checked, %0d hot samples",
			checked_cnt, hot_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
sv/hps_pkg.sv
sv/hps_if.sv
sv/hps_ram.sv
sv/hps_cfg.sv
sv/hps_lane.sv
sv/hps_merge.sv
sv/hot_pixel_suppressor_top.sv
sim/testbench.sv
